// ===== hdl/lru_page_replacement_top_assert.svh =====
// assertion macros for the lru page replacement top level
// expects clk_i and rst_ni in the scope of each use
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LRUPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LRUPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lrupr_pkg.sv =====
// shared types and constants for the lru page replacement block
// no dependencies
package lrupr_pkg;

  localparam int CFG_W     = 5;
  localparam int CFG_RESET = 16;
  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 32;
  localparam int FAULT_W   = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;   // latch the request page, clear the search trackers
    logic step;    // read the next frame entry
    logic commit;  // update the frame tables and load the result register
  } lrupr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;      // the entry read this cycle is the last active frame
    logic out_free;  // the result register can take a new result
  } lrupr_sts_t;

endpackage

// ===== hdl/lrupr_if.sv =====
// valid/ready channel interfaces for the lru page replacement block
// depends on lrupr_pkg
interface lrupr_req_if #(
  parameter int PAGE_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface lrupr_rsp_if import lrupr_pkg::*; #(
  parameter int PAGE_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [SLOT_W-1:0]    frame_slot;
  logic                 victim_valid;
  logic [PAGE_BITS-1:0] victim_page;
  logic [FAULT_W-1:0]   fault_total;

  modport source (output valid, output hit, output frame_slot, output victim_valid,
                  output victim_page, output fault_total, input ready);
  modport sink   (input valid, input hit, input frame_slot, input victim_valid,
                  input victim_page, input fault_total, output ready);
endinterface

interface lrupr_cfg_if import lrupr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] num_frames;

  modport source (output valid, output num_frames, input ready);
  modport sink   (input valid, input num_frames, output ready);
endinterface

// ===== hdl/lrupr_ctrl.sv =====
// sequencing state machine for the lru page replacement block
// depends on lrupr_pkg
module lrupr_ctrl import lrupr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lrupr_sts_t sts_i,
  output lrupr_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FLUSH  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = S_FLUSH;
        end
      end
      // last read entry goes through the compare stage
      S_FLUSH: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/lrupr_dp.sv =====
// frame tables, search trackers and result register of the lru block
// depends on lrupr_pkg
module lrupr_dp import lrupr_pkg::*; #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrupr_cmd_t           cmd_i,
  output lrupr_sts_t           sts_o,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 hit_o,
  output logic [SLOT_W-1:0]    frame_slot_o,
  output logic                 victim_valid_o,
  output logic [PAGE_BITS-1:0] victim_page_o,
  output logic [FAULT_W-1:0]   fault_total_o
);

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FCNT_W = $clog2(FRAMES + 1);
  localparam int CNT_W  = (FCNT_W > CFG_W) ? FCNT_W : CFG_W;
  localparam int CFG_RST_VAL = (FRAMES < CFG_RESET) ? FRAMES : CFG_RESET;

  // frame tables
  logic [PAGE_BITS-1:0] page_mem  [FRAMES];
  logic [TIME_W-1:0]    stamp_mem [FRAMES];
  logic [FRAMES-1:0]    valid_q;

  logic [CFG_W-1:0]     num_q;
  logic [TIME_W-1:0]    time_q;
  logic [FAULT_W-1:0]   fault_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [IDX_W-1:0]     idx_q;

  // read stage
  logic                 rd_go_q;
  logic                 rd_v_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic [PAGE_BITS-1:0] rd_page_q;
  logic [TIME_W-1:0]    rd_stamp_q;

  // search trackers
  logic                 hit_q, emp_q, min_any_q;
  logic [IDX_W-1:0]     hit_idx_q, emp_idx_q, min_idx_q;
  logic [TIME_W-1:0]    min_stamp_q;
  logic [PAGE_BITS-1:0] min_page_q;

  // result register
  logic                 out_valid_q;
  logic                 out_hit_q, out_vv_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic [PAGE_BITS-1:0] out_victim_q;
  logic [FAULT_W-1:0]   out_fault_q;

  logic [CNT_W-1:0]     num_ext, n_act;
  logic [IDX_W-1:0]     slot;
  logic                 evict;
  logic [FAULT_W-1:0]   fault_d;

  // active frame count, clamped to 1..FRAMES
  always_comb begin
    num_ext = CNT_W'(num_q);
    if (num_ext == '0) begin
      n_act = CNT_W'(1);
    end else if (num_ext > CNT_W'(FRAMES)) begin
      n_act = CNT_W'(FRAMES);
    end else begin
      n_act = num_ext;
    end
  end

  assign sts_o.last     = (CNT_W'(idx_q) + CNT_W'(1)) == n_act;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign slot    = hit_q ? hit_idx_q : (emp_q ? emp_idx_q : min_idx_q);
  assign evict   = !hit_q && !emp_q;
  assign fault_d = (hit_q || fault_q == '1) ? fault_q : fault_q + FAULT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      rd_page_q  <= page_mem[idx_q];
      rd_stamp_q <= stamp_mem[idx_q];
    end
    if (cmd_i.commit) begin
      stamp_mem[slot] <= time_q;
      if (!hit_q) begin
        page_mem[slot] <= page_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      page_q <= page_i;
    end
    if (cmd_i.step) begin
      rd_v_q   <= valid_q[idx_q];
      rd_idx_q <= idx_q;
    end
    if (cmd_i.commit) begin
      out_hit_q    <= hit_q;
      out_slot_q   <= SLOT_W'(slot);
      out_vv_q     <= evict;
      out_victim_q <= evict ? min_page_q : '0;
      out_fault_q  <= fault_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      num_q       <= CFG_W'(CFG_RST_VAL);
      time_q      <= '0;
      fault_q     <= '0;
      idx_q       <= '0;
      rd_go_q     <= 1'b0;
      hit_q       <= 1'b0;
      emp_q       <= 1'b0;
      min_any_q   <= 1'b0;
      hit_idx_q   <= '0;
      emp_idx_q   <= '0;
      min_idx_q   <= '0;
      min_stamp_q <= '0;
      min_page_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        num_q <= cfg_data_i;
      end
      rd_go_q <= cmd_i.step;
      if (cmd_i.start) begin
        idx_q     <= '0;
        hit_q     <= 1'b0;
        emp_q     <= 1'b0;
        min_any_q <= 1'b0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (rd_go_q) begin
        if (rd_v_q && rd_page_q == page_q && !hit_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= rd_idx_q;
        end
        if (!rd_v_q && !emp_q) begin
          emp_q     <= 1'b1;
          emp_idx_q <= rd_idx_q;
        end
        // strict compare keeps the lowest index on equal stamps
        if (rd_v_q && (!min_any_q || rd_stamp_q < min_stamp_q)) begin
          min_any_q   <= 1'b1;
          min_idx_q   <= rd_idx_q;
          min_stamp_q <= rd_stamp_q;
          min_page_q  <= rd_page_q;
        end
      end
      if (cmd_i.commit) begin
        valid_q[slot] <= 1'b1;
        time_q        <= time_q + TIME_W'(1);
        fault_q       <= fault_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign frame_slot_o   = out_slot_q;
  assign victim_valid_o = out_vv_q;
  assign victim_page_o  = out_victim_q;
  assign fault_total_o  = out_fault_q;

endmodule

// ===== hdl/lru_page_replacement_top.sv =====
// top level of the counter-based lru page replacement block
// depends on lrupr_pkg, lrupr_if, lrupr_ctrl, lrupr_dp and the assert header
//
//   channel | dir | payload                                   | fires on
//   cfg     | in  | num_frames                                | valid & ready
//   req     | in  | page                                      | valid & ready
//   rsp     | out | hit, frame_slot, victim_valid,            | valid & ready
//           |     | victim_page, fault_total                  |
//
// a request passes an accept state, then a scan of the n active frames (1..FRAMES),
// reading the frame tables one entry per cycle, then a flush state for the last
// compare and a commit state that updates the tables
// the update waits while the result register holds an unread result
// reset empties every frame through its valid flop, no clearing pass
// the cfg channel is always ready; write it only while the block is idle
module lru_page_replacement_top import lrupr_pkg::*; #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lrupr_cfg_if.sink   cfg,
  lrupr_req_if.sink   req,
  lrupr_rsp_if.source rsp
);

`include "lru_page_replacement_top_assert.svh"

  lrupr_cmd_t cmd;
  lrupr_sts_t sts;

  // register writes land at once
  assign cfg.ready = 1'b1;

  // controller: accept, scan, flush, commit
  lrupr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: frame tables, trackers for hit / empty / oldest, result register
  lrupr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .page_i         (req.page),
    .cfg_valid_i    (cfg.valid),
    .cfg_data_i     (cfg.num_frames),
    .out_ready_i    (rsp.ready),
    .out_valid_o    (rsp.valid),
    .hit_o          (rsp.hit),
    .frame_slot_o   (rsp.frame_slot),
    .victim_valid_o (rsp.victim_valid),
    .victim_page_o  (rsp.victim_page),
    .fault_total_o  (rsp.fault_total)
  );

  // a hit never evicts
  `LRUPR_ASSERT_NOW(a_hit_no_evict, rsp.valid, !(rsp.hit && rsp.victim_valid), "hit with eviction")
  // victim page reads zero when nothing was evicted
  `LRUPR_ASSERT_NOW(a_victim_zero, rsp.valid && !rsp.victim_valid, rsp.victim_page == '0, "victim page not zero")
  // only one request in flight
  `LRUPR_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "request taken while busy")

endmodule
